// ===== sv/plvt_pkg.sv =====
// Shared types, codes and helpers for the pixel value label table.
`timescale 1ns / 1ps
package plvt_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_NODATA = 2'd0,
    ST_HIT    = 2'd1,
    ST_NEW    = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  localparam int unsigned PIXEL_KEY_W = 64;
  localparam int unsigned KEY_BYTES_W = 4;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned KEY_BYTES_MAX = 8;

  // Control part of a request travelling down the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 done;
    status_e              status;
    logic [INDEX_W-1:0]   index;
  } probe_ctl_t;

  // Byte mask for the configured key width, saturated to 1..8 bytes
  function automatic logic [PIXEL_KEY_W-1:0] key_mask(input logic [KEY_BYTES_W-1:0] kb);
    logic [KEY_BYTES_W-1:0] nb;
    logic [PIXEL_KEY_W-1:0] m;
    nb = kb;
    if (nb == '0) begin
      nb = KEY_BYTES_W'(1);
    end
    if (nb > KEY_BYTES_W'(KEY_BYTES_MAX)) begin
      nb = KEY_BYTES_W'(KEY_BYTES_MAX);
    end
    m = '0;
    for (int b = 0; b < KEY_BYTES_MAX; b++) begin
      if (KEY_BYTES_W'(b) < nb) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== sv/plvt_if.sv =====
// Handshake interfaces for pixel requests and label results.
`timescale 1ns / 1ps
interface plvt_in_if;
  logic                                valid;
  logic                                ready;
  logic [plvt_pkg::PIXEL_KEY_W-1:0]    pixel_key;
  logic                                is_nodata;

  modport source (output valid, output pixel_key, output is_nodata, input ready);
  modport sink   (input valid, input pixel_key, input is_nodata, output ready);
endinterface

interface plvt_out_if;
  logic                                valid;
  logic                                ready;
  logic [plvt_pkg::INDEX_W-1:0]        feature_index;
  logic [1:0]                          status;

  modport source (output valid, output feature_index, output status, input ready);
  modport sink   (input valid, input feature_index, input status, output ready);
endinterface

// ===== sv/plvt_cell.sv =====
// One table cell: holds one stored key and one stage of the request chain.
`timescale 1ns / 1ps
module plvt_cell #(
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned CNT_W    = 9,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic [CNT_W-1:0]       count_i,
  input  plvt_pkg::probe_ctl_t   ctl_i,
  input  logic [KEY_BITS-1:0]    key_i,
  output plvt_pkg::probe_ctl_t   ctl_o,
  output logic [KEY_BITS-1:0]    key_o,
  output logic                   wr_o
);

  localparam logic [CNT_W-1:0]                 CellCnt = CNT_W'(CELL_IDX);
  localparam logic [plvt_pkg::INDEX_W-1:0]     CellIdx = plvt_pkg::INDEX_W'(CELL_IDX);

  logic [KEY_BITS-1:0]   slot_q;
  logic [KEY_BITS-1:0]   key_q;
  plvt_pkg::probe_ctl_t  ctl_q, ctl_d;
  logic                  wr;

  // Resolve the passing request against this cell's slot
  always_comb begin
    ctl_d = ctl_i;
    wr    = 1'b0;
    if (ctl_i.valid && !ctl_i.done) begin
      if (CellCnt < count_i) begin
        if (slot_q == key_i) begin
          ctl_d.done   = 1'b1;
          ctl_d.status = plvt_pkg::ST_HIT;
          ctl_d.index  = CellIdx;
        end
      end else if (CellCnt == count_i) begin
        // first free slot: append
        wr           = 1'b1;
        ctl_d.done   = 1'b1;
        ctl_d.status = plvt_pkg::ST_NEW;
        ctl_d.index  = CellIdx;
      end
    end
  end

  assign wr_o = wr & adv_i;

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  // Stage key and stored slot
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      key_q <= key_i;
    end
    if (wr_o) begin
      slot_q <= key_i;
    end
  end

  assign ctl_o = ctl_q;
  assign key_o = key_q;

endmodule

// ===== sv/pixel_value_label_table_top.sv =====
// Pixel value label table: top level with the cell chain and entry count.
//
// Usage:
//   pix_i carries one pixel request (pixel_key, is_nodata); res_o returns one
//   result (feature_index, status) for every request, in request order.
//   cfg_we_i/cfg_wdata_i write key_bytes (low bytes of the key that count);
//   write it only while no request is in flight.
// Throughput:
//   A request walks a chain of MAX_ENTRIES registered cells, one cell per
//   cycle while the chain advances. A new request can be accepted every
//   cycle while the chain advances; a key appended by one request is seen
//   by the next because each request trails the one ahead by at least one cell.
// Reset:
//   Entry count goes to zero, key_bytes to 1, and the chain empties. Stored
//   keys are not cleared; cells at or above the count are never compared.
// Stall:
//   When res_o is held by the receiver the whole chain freezes and pix_i
//   deasserts ready; nothing is lost or reordered.
`timescale 1ns / 1ps
module pixel_value_label_table_top #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [plvt_pkg::KEY_BYTES_W-1:0]    cfg_wdata_i,
  plvt_in_if.sink                             pix_i,
  plvt_out_if.source                          res_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  logic [plvt_pkg::KEY_BYTES_W-1:0]  key_bytes_q;
  logic [CntW-1:0]                   count_q, count_d;
  logic                              adv;
  logic [MAX_ENTRIES-1:0]            wr;
  plvt_pkg::probe_ctl_t              ctl [MAX_ENTRIES+1];
  logic [KEY_BITS-1:0]               key [MAX_ENTRIES+1];
  logic [plvt_pkg::PIXEL_KEY_W-1:0]  masked;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q <= plvt_pkg::KEY_BYTES_W'(1);
    end else if (cfg_we_i) begin
      key_bytes_q <= cfg_wdata_i;
    end
  end

  // Chain moves when the output register is free or being drained
  assign adv         = !ctl[MAX_ENTRIES].valid || res_o.ready;
  assign pix_i.ready = adv;

  // Chain head: masked key, no-data requests enter already resolved
  assign masked          = pix_i.pixel_key & plvt_pkg::key_mask(key_bytes_q);
  assign key[0]          = masked[KEY_BITS-1:0];
  assign ctl[0].valid    = pix_i.valid;
  assign ctl[0].done     = pix_i.is_nodata;
  assign ctl[0].status   = plvt_pkg::ST_NODATA;
  assign ctl[0].index    = '0;

  // Cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    plvt_cell #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CntW),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .count_i (count_q),
      .ctl_i   (ctl[i]),
      .key_i   (key[i]),
      .ctl_o   (ctl[i+1]),
      .key_o   (key[i+1]),
      .wr_o    (wr[i])
    );
  end

  // Entry count: only the cell at the count can append
  assign count_d = (|wr) ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Chain tail: an unresolved request found no slot
  assign res_o.valid         = ctl[MAX_ENTRIES].valid;
  assign res_o.status        = ctl[MAX_ENTRIES].done ? ctl[MAX_ENTRIES].status
                                                     : plvt_pkg::ST_FULL;
  assign res_o.feature_index = ctl[MAX_ENTRIES].done ? ctl[MAX_ENTRIES].index
                                                     : '0;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr))
    else $error("more than one cell appended in a cycle");

  a_write_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|wr) |-> adv)
    else $error("append while chain stalled");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(count_q))
    else $error("entry count moved during stall");

  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == plvt_pkg::ST_NODATA ||
                     res_o.status == plvt_pkg::ST_FULL)) |-> res_o.feature_index == '0)
    else $error("nonzero index on no-data or full result");

endmodule
